// ===== hdl/hdtf_pkg.sv =====
// Package for the half-to-single depth scaler.
// Holds binary16/binary32 field constants; no dependencies.
package hdtf_pkg;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam int unsigned HALF_BIAS_ADJ = 112;
   localparam logic [4:0] EXP_MAX_FIELD = 5'd31;
endpackage

// ===== hdl/half_depth_to_float_scale_mask.sv =====
// Half-precision depth sample to ten-times single-precision value with a validity mask.
// One transaction enters per cycle unless the result side stalls: input register, one
// layer of logic (leading-one search over 15 bits, a 15-bit multiply by ten, normalize),
// and a result register.
// Uses hdtf_pkg.
module half_depth_to_float_scale_mask (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_half_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_depth_bits,
   output logic        rsp_invalid
);
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_half_ff;
   logic        out_valid_ff;
   logic [31:0] out_bits_ff;
   logic        out_inv_ff;
   logic        adv_out;

   // Output stage moves when empty or drained; input stage when its item moves on.
   assign adv_out   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !adv_out;
   assign in_valid_in = req_valid || (in_valid_ff && !adv_out);

   // Compute: value = sig * 2^(e-25) with sig 11 bits; times ten gives 15-bit product.
   logic        sgn;
   logic [4:0]  efld;
   logic [9:0]  mant;
   logic [10:0] sig;
   logic [8:0]  e_unb;      // biased single exponent of sig's bit 10 position
   logic [14:0] prod;
   logic [3:0]  top;
   logic [7:0]  exp_out;
   logic [22:0] frac_out;
   logic [31:0] res_bits;
   logic        is_zero, too_big, bad;
   logic [3:0]  lz;

   always_comb begin
      sgn  = in_half_ff[15];
      efld = in_half_ff[14:10];
      mant = in_half_ff[9:0];
      // Subnormal: value = mant * 2^-24, treat as exponent field 1 with no hidden bit.
      if (efld != 5'd0) begin
         sig   = {1'b1, mant};
         e_unb = 9'(efld) + 9'(hdtf_pkg::HALF_BIAS_ADJ);
      end else begin
         sig   = {1'b0, mant};
         e_unb = 9'd1 + 9'(hdtf_pkg::HALF_BIAS_ADJ);
      end
      prod = ({4'd0, sig} << 3) + ({4'd0, sig} << 1);
      top = 4'd0;
      for (int i = 0; i < 15; i++)
         if (prod[i]) top = 4'(i);
      lz = 4'd14 - top;
      // Bit 10 of sig sits at weight e_unb; product bit top at e_unb + top - 10.
      exp_out  = 8'(e_unb + 9'(top) - 9'd10);
      frac_out = 23'({8'd0, prod << lz} << 9);
      res_bits = {sgn, exp_out, frac_out};
      is_zero  = (prod == 15'd0);
      // 100 = 1.5625 * 2^6 (biased 133); above means exponent > 133 or equal with frac > .5625.
      too_big  = !sgn && ((exp_out > 8'd133) ||
                 ((exp_out == 8'd133) && (frac_out > 23'h480000)) ||
                 (efld == hdtf_pkg::EXP_MAX_FIELD));
      bad      = is_zero || too_big;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_out) out_valid_ff <= in_valid_ff;
         in_valid_ff <= in_valid_in;
      end
      if (!req_stall && req_valid) in_half_ff <= req_half_sample;
      if (adv_out && in_valid_ff) begin
         out_bits_ff <= bad ? hdtf_pkg::QNAN_BITS : res_bits;
         out_inv_ff  <= bad;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_depth_bits = out_bits_ff;
   assign rsp_invalid    = out_inv_ff;

   a_flag_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_depth_bits == hdtf_pkg::QNAN_BITS)
      else $error("invalid result without NaN");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_depth_bits))
      else $error("stalled result changed");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted transaction lost");
endmodule

// ===== tb/tb_half_depth_to_float_scale_mask.sv =====
`timescale 1ns / 100ps
// Testbench for half_depth_to_float_scale_mask: directed and random binary16 samples,
// scaled-by-ten prediction with the NaN mask, random gaps and stalls. Uses hdtf_pkg.
module tb_half_depth_to_float_scale_mask;

   typedef struct packed {
      logic [31:0] depth_bits;
      logic        invalid;
   } depth_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_half_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_depth_bits;
   logic        rsp_invalid;

   logic [15:0]      pending_samples[$];
   depth_result_type expected_depths[$];
   int               error_count;
   int               result_count;
   int               nan_count;
   int               send_gap;
   int               recv_gap;
   bit               hold_sender;
   logic             req_fire;
   logic             rsp_fire;

   half_depth_to_float_scale_mask dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_half_sample(req_half_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_depth_bits(rsp_depth_bits), .rsp_invalid(rsp_invalid)
   );

   // Widen to binary32, scale by ten exactly, then mask zero and values above 100.
   function automatic depth_result_type scale_depth(input logic [15:0] h);
      depth_result_type r;
      logic [4:0]    ex;
      logic [9:0]    mt;
      logic [10:0]   sig;
      logic [14:0]   prod;
      int            e2;
      int            top;
      logic [31:0]   f;
      ex = h[14:10];
      mt = h[9:0];
      r.invalid = 1'b0;
      r.depth_bits = hdtf_pkg::QNAN_BITS;
      if (ex == 0 && mt == 0) begin
         r.invalid = 1'b1;
         return r;
      end
      // value = sig * 2^(e2), sig integer
      if (ex == 0) begin
         sig = {1'b0, mt};
         e2 = -24;
      end else begin
         sig = {1'b1, mt};
         e2 = int'(ex) - 25;
      end
      prod = sig * 15'd10;
      top = 0;
      for (int i = 0; i < 15; i++)
         if (prod[i]) top = i;
      // magnitude = prod * 2^e2 ; above 100 when prod > 100 * 2^-e2
      if (!h[15] && (real'(prod) * (2.0 ** e2) > 100.0)) begin
         r.invalid = 1'b1;
         return r;
      end
      f = '0;
      f[31] = h[15];
      f[30:23] = 8'(top + e2 + 127);
      f[22:0] = 23'((32'(prod) << (23 - top)) & 32'h007F_FFFF);
      r.depth_bits = f;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Timeout at %0t", $time);
      $display("Regression FAIL");
      $finish;
   end

   // Record the handshakes seen at the rising edge for the falling-edge drivers.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      rsp_fire <= rsp_valid && !rsp_stall;
   end

   // Driver: present at the falling edge, advance after an accepted transaction.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (req_fire) begin
         pending_samples.pop_front();
         send_gap = int'($urandom_range(0, 6) * $urandom_range(0, 1));
         if (send_gap == 0 && pending_samples.size() > 0 && !hold_sender) begin
            req_half_sample <= pending_samples[0];
         end else begin
            req_valid <= 1'b0;
            req_half_sample <= 16'($urandom);
         end
      end else if (!req_valid) begin
         if (send_gap > 0) send_gap = send_gap - 1;
         else if (pending_samples.size() > 0 && !hold_sender) begin
            req_valid <= 1'b1;
            req_half_sample <= pending_samples[0];
         end
      end
   end

   // Stall pattern for the result side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_fire) begin
         recv_gap <= int'($urandom_range(0, 6) * $urandom_range(0, 1));
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on accepted input, compare on accepted output.
   always @(posedge clock) begin
      depth_result_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_depths.push_back(scale_depth(req_half_sample));
         if (rsp_valid && !rsp_stall) begin
            if (expected_depths.size() == 0) begin
               $display("%0t unexpected result depth_bits=%h invalid=%b",
                        $time, rsp_depth_bits, rsp_invalid);
               error_count++;
            end else begin
               exp_r = expected_depths.pop_front();
               result_count++;
               if (exp_r.invalid) nan_count++;
               if (rsp_depth_bits !== exp_r.depth_bits) begin
                  $display("%0t depth_bits expected %h actual %h",
                           $time, exp_r.depth_bits, rsp_depth_bits);
                  error_count++;
               end
               if (rsp_invalid !== exp_r.invalid) begin
                  $display("%0t invalid expected %b actual %b",
                           $time, exp_r.invalid, rsp_invalid);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [15:0] directed[$];
      logic [15:0] s;
      int          idle;
      error_count = 0;
      result_count = 0;
      nan_count = 0;
      hold_sender = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_half_sample = '0;
      rsp_stall = 1'b0;
      // zeros, subnormals, exponent 31, both sides of the 100 limit, negatives
      directed = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF, 16'h0200,
                   16'h7C00, 16'h7FFF, 16'hFC00, 16'hFFFF, 16'h4900, 16'h4901,
                   16'h48FF, 16'h3C00, 16'hBC00, 16'h0400, 16'h5555, 16'hAAAA,
                   16'h2E66, 16'hC900, 16'h7BFF};
      foreach (directed[i]) pending_samples.push_back(directed[i]);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0);
      // hold off until every result is back
      hold_sender = 1'b1;
      wait (expected_depths.size() == 0);
      hold_sender = 1'b0;
      for (int n = 0; n < 600; n++) begin
         // mostly values near the valid range, the rest any pattern
         if ($urandom_range(0, 2) == 0) s = 16'($urandom);
         else s = {1'($urandom), 5'($urandom_range(0, 19)), 10'($urandom)};
         pending_samples.push_back(s);
      end
      wait (pending_samples.size() == 0);
      wait (expected_depths.size() == 0);
      idle = 0;
      while (idle < 20) begin
         @(posedge clock);
         idle++;
      end
      $display("Checked %0d results, %0d masked as NaN, with random gaps and stalls.",
               result_count, nan_count);
      if (error_count == 0 && expected_depths.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/hdtf_pkg.sv
hdl/half_depth_to_float_scale_mask.sv
tb/tb_half_depth_to_float_scale_mask.sv
